@@ hdl/msm_pkg.sv @@
// Shared types and constants for the multi-pattern stream matcher.
// No dependencies; imported by every module of the block.
package msm_pkg;

	localparam int TOKEN_COUNT   = 4;
	localparam int MAX_TOKEN_LEN = 8;
	localparam int TOKEN_SLOTS   = 4;

	localparam int BYTE_W      = 8;
	localparam int CHARS_W     = 64;
	localparam int LEN_W       = 4;
	localparam int TOKEN_IDX_W = 2;
	localparam int SLOT_W      = 2;
	localparam int REG_IDX_W   = 3;
	localparam int WIN_AW      = (MAX_TOKEN_LEN > 1) ? $clog2(MAX_TOKEN_LEN) : 1;

	// register map
	localparam logic [REG_IDX_W-1:0] REG_BYTES_BASE  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_LENGTH_BASE = 3'd4;

	// result queue
	localparam int RQ_DEPTH = 4;
	localparam int RQ_AW    = 2;
	localparam int RQ_CW    = 3;

	typedef struct packed {
		logic [BYTE_W-1:0] stream_byte;
		logic              end_of_stream;
	} in_item_t;

	typedef struct packed {
		logic                   found;
		logic [TOKEN_IDX_W-1:0] token_index;
	} out_item_t;

	typedef struct packed {
		logic [TOKEN_SLOTS-1:0][CHARS_W-1:0] chars;
		logic [TOKEN_SLOTS-1:0][LEN_W-1:0]   len;
	} token_cfg_t;

	typedef struct packed {
		logic      valid;
		out_item_t data;
	} res_push_t;

endpackage

@@ hdl/msm_front.sv @@
// Front end: sliding byte window, parallel token compare and result classification.
// Depends on msm_pkg.
module msm_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  msm_pkg::in_item_t  item,
	input  msm_pkg::token_cfg_t cfg,
	output msm_pkg::res_push_t res
);
	import msm_pkg::*;

	logic [MAX_TOKEN_LEN-1:0][BYTE_W-1:0] win_q;
	logic [MAX_TOKEN_LEN-1:0][BYTE_W-1:0] win_nx;
	logic [LEN_W-1:0]                     seen_q;
	logic [LEN_W-1:0]                     seen_nx;
	logic [TOKEN_COUNT-1:0]               hit;
	logic [LEN_W-1:0]                     pos;
	logic [TOKEN_IDX_W-1:0]               hit_idx;
	logic                                 any_hit;

	always_comb begin
		win_nx[0] = item.stream_byte;
		for (int i = 1; i < MAX_TOKEN_LEN; i++) begin
			win_nx[i] = win_q[i-1];
		end
		seen_nx = (seen_q < LEN_W'(MAX_TOKEN_LEN)) ? seen_q + LEN_W'(1) : seen_q;
	end

	// token t hits when its last len window bytes equal its characters,
	// first character being the oldest of them
	always_comb begin
		pos = '0;
		for (int t = 0; t < TOKEN_COUNT; t++) begin
			hit[t] = (cfg.len[t] != '0) && (cfg.len[t] <= LEN_W'(MAX_TOKEN_LEN))
				&& (seen_nx >= cfg.len[t]);
			for (int k = 0; k < MAX_TOKEN_LEN; k++) begin
				if (LEN_W'(k) < cfg.len[t]) begin
					pos = cfg.len[t] - LEN_W'(k) - LEN_W'(1);
					if (win_nx[pos[WIN_AW-1:0]] != cfg.chars[t][BYTE_W*k +: BYTE_W]) begin
						hit[t] = 1'b0;
					end
				end
			end
		end
	end

	// lowest index wins
	always_comb begin
		hit_idx = '0;
		for (int t = TOKEN_COUNT - 1; t >= 0; t--) begin
			if (hit[t]) begin
				hit_idx = TOKEN_IDX_W'(t);
			end
		end
		any_hit = |hit;
	end

	always_comb begin
		res.valid            = accept && (any_hit || item.end_of_stream);
		res.data.found       = any_hit;
		res.data.token_index = any_hit ? hit_idx : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (accept) begin
			seen_q <= res.valid ? '0 : seen_nx;
		end
	end

	// window bytes are only read once seen_q covers them
	always_ff @(posedge clk) begin
		if (accept) begin
			win_q <= win_nx;
		end
	end

endmodule

@@ hdl/msm_fifo.sv @@
// Back end: short result queue between the matcher and the result port.
// Depends on msm_pkg.
module msm_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  msm_pkg::res_push_t wr,
	input  logic               rd_en,
	output msm_pkg::out_item_t rd_data,
	output logic               full,
	output logic               empty,
	output logic [msm_pkg::RQ_CW-1:0] level
);
	import msm_pkg::*;

	out_item_t          mem_q [RQ_DEPTH];
	logic [RQ_AW-1:0]   wr_ptr_q;
	logic [RQ_AW-1:0]   rd_ptr_q;
	logic [RQ_CW-1:0]   count_q;

	assign full    = (count_q == RQ_CW'(RQ_DEPTH));
	assign empty   = (count_q == '0);
	assign level   = count_q;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr.valid) begin
				wr_ptr_q <= wr_ptr_q + RQ_AW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + RQ_AW'(1);
			end
			unique case ({wr.valid, rd_en})
				2'b10:   count_q <= count_q + RQ_CW'(1);
				2'b01:   count_q <= count_q - RQ_CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr.valid) begin
			mem_q[wr_ptr_q] <= wr.data;
		end
	end

endmodule

@@ hdl/multi_pattern_stream_matcher_unit.sv @@
// Top level of the multi-pattern stream matcher: token registers, matcher and result queue.
// Depends on msm_pkg, msm_front and msm_fifo.
//
// Usage:
//   Input queue: drive item and raise push; a word is taken at an edge with push high
//   and full low. One byte per clock, back to back, while full is low.
//   Result queue: while empty is low, result holds the oldest result word; pop takes it.
//   A result comes for a byte that completes an enabled token (found = 1, lowest index
//   wins) or for a last byte that completes none (found = 0); other bytes give none.
//   The result of a byte enters the result queue at the edge that takes the byte.
//   One byte per cycle while full is low; window shift and compare are combinational.
//   A four-word result queue decouples the two sides; full rises only when four
//   results wait, so a stalled receiver stops input only then.
//   Configuration: write_enable, reg_index, write_data; indexes 0..3 hold token bytes,
//   4..7 token lengths (zero or above eight disables). Write only while idle.
//   Reset (arst_n low): tokens disabled, history and result queue cleared.
module multi_pattern_stream_matcher_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	output logic                                 full,
	input  msm_pkg::in_item_t                    item,
	output logic                                 empty,
	input  logic                                 pop,
	output msm_pkg::out_item_t                   result,
	input  logic                                 write_enable,
	input  logic [msm_pkg::REG_IDX_W-1:0]        reg_index,
	input  logic [msm_pkg::CHARS_W-1:0]          write_data
);
	import msm_pkg::*;

	token_cfg_t        cfg_q;
	res_push_t         res;
	logic              accept;
	logic              rd_en;
	logic [RQ_CW-1:0]  level;
	logic [SLOT_W-1:0] slot;

	assign accept = push && !full;
	assign rd_en  = pop && !empty;
	assign slot   = reg_index[SLOT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (write_enable) begin
			if (reg_index < REG_LENGTH_BASE) begin
				cfg_q.chars[slot] <= write_data;
			end else begin
				cfg_q.len[slot] <= write_data[LEN_W-1:0];
			end
		end
	end

	msm_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (item),
		.cfg    (cfg_q),
		.res    (res)
	);

	msm_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (res),
		.rd_en   (rd_en),
		.rd_data (result),
		.full    (full),
		.empty   (empty),
		.level   (level)
	);

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level <= RQ_CW'(RQ_DEPTH))
		else $error("result queue level beyond depth");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !res.valid)
		else $error("result word written into full queue");

	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.end_of_stream && !rd_en) |=> !empty)
		else $error("last byte produced no result word");

	a_miss_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !result.found) |-> (result.token_index == '0))
		else $error("miss result carries a token index");

endmodule
